// ===== rtl/dert_pkg.sv =====
// Shared constants and types for the delayed event report table.
package dert_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETAIN_TIME = 2'd1;

	localparam logic [15:0] WAIT_DELAY_RST = 16'd30;
	localparam logic [23:0] RETAIN_TIME_RST = 24'(60 * 60 * 24);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_TICK_DONE = 2'd2;
	localparam logic [1:0] KIND_REMOVE = 2'd3;

	localparam logic [1:0] ST_REFRESHED = 2'd0;
	localparam logic [1:0] ST_NEW = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_UNREPORTED = 2'd0;
	localparam logic [1:0] ST_REPORTED = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL
	} state_t;

endpackage

// ===== rtl/delayed_event_report_table.sv =====
// Delayed event report table: debounce table for path-lost events.
//
// Requests: drive opcode and the key fields with start high; a request is taken
// at a rising edge with start high and busy low. Opcode 3 is taken and ignored.
// Add, tick and remove walk the slots one per cycle through a single compare/add
// unit and then take a closing step, which a matching remove skips; busy stays
// high through both, and no new request is taken while it is high.
// Add: one ack (kind 0), strobed in the cycle after the closing step;
// the strobe rises together with the fall of busy.
// Tick: one report (kind 1) per overdue unreported slot, in slot order, strobed
// in the cycle after that slot is visited; then a tick-done item (kind 2).
// Remove: the status (kind 3) strobes in the cycle after the first matching slot,
// which ends the walk early, or after the closing step when no slot matches.
// Results show on the output ports for exactly one cycle with strobe high; the
// receiver cannot stall them. last marks the final result of each request.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 wait_delay,
// 1 retain_time) and cfg_data; cfg_ready is always high. Write only while idle.
// Reset (arst_n low) empties the table and restores wait_delay 30 and
// retain_time 86400; there is no clearing pass.
module delayed_event_report_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic [31:0]                       event_number,
	input  logic [31:0]                       serial_number,
	input  logic [7:0]                        far_path,
	input  logic [7:0]                        far_cluster,
	input  logic [7:0]                        near_path,
	input  logic [7:0]                        link_flag,
	input  logic [31:0]                       now_seconds,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dert_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dert_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              strobe,
	output logic [1:0]                        kind,
	output logic [1:0]                        status,
	output logic [31:0]                       out_event,
	output logic [31:0]                       out_serial,
	output logic [7:0]                        out_far_path,
	output logic [7:0]                        out_far_cluster,
	output logic [7:0]                        out_near_path,
	output logic [7:0]                        out_link_flag,
	output logic                              last
);

	localparam int IW = dert_pkg::IDX_W;
	localparam int N = dert_pkg::ENTRIES;

	dert_pkg::state_t state_q, state_d;
	logic [IW-1:0] idx_q;

	logic [1:0]  op_q;
	logic [31:0] ev_q, sn_q, key_paths_q, now_q;

	logic        slot_valid_q [N];
	logic [31:0] slot_event_q [N];
	logic [31:0] slot_serial_q [N];
	logic [31:0] slot_paths_q [N];
	logic [32:0] slot_deadline_q [N];
	logic        slot_reported_q [N];

	logic          hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;

	logic [15:0] wait_delay_q;
	logic [23:0] retain_time_q;

	logic        strobe_q, last_q;
	logic [1:0]  kind_q, status_q;
	logic [31:0] out_event_q, out_serial_q, out_paths_q;

	logic        accept;
	logic        cur_valid, cur_reported, key_eq, full_eq, overdue, expired, last_slot;
	logic [32:0] cur_deadline;
	logic [33:0] retain_sum;
	logic        emit, emit_last, emit_report, drop_cur;
	logic [1:0]  emit_kind, emit_status;
	logic [IW-1:0] add_idx;

	assign accept = start && (state_q == dert_pkg::S_IDLE);
	assign busy = (state_q != dert_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// shared compare / add unit, applied to the slot under the walk pointer
	assign cur_valid = slot_valid_q[idx_q];
	assign cur_reported = slot_reported_q[idx_q];
	assign cur_deadline = slot_deadline_q[idx_q];
	assign key_eq = (slot_serial_q[idx_q] == sn_q) && (slot_paths_q[idx_q] == key_paths_q);
	assign full_eq = key_eq && (slot_event_q[idx_q] == ev_q);
	assign overdue = cur_deadline < {1'b0, now_q};
	assign retain_sum = {1'b0, cur_deadline} + {10'd0, retain_time_q};
	assign expired = retain_sum < {2'b00, now_q};
	assign last_slot = (idx_q == IW'(N - 1));
	assign add_idx = hit_q ? hit_idx_q : free_idx_q;

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		emit_last = 1'b0;
		emit_report = 1'b0;
		emit_kind = dert_pkg::KIND_ACK;
		emit_status = dert_pkg::ST_NONE;
		drop_cur = 1'b0;
		unique case (state_q)
			dert_pkg::S_IDLE: begin
				if (accept && (opcode == dert_pkg::OP_ADD || opcode == dert_pkg::OP_TICK ||
						opcode == dert_pkg::OP_REMOVE)) begin
					state_d = dert_pkg::S_SCAN;
				end
			end
			dert_pkg::S_SCAN: begin
				case (op_q)
					dert_pkg::OP_ADD: begin
						if (last_slot) state_d = dert_pkg::S_TAIL;
					end
					dert_pkg::OP_TICK: begin
						if (cur_valid && overdue) begin
							if (!cur_reported) begin
								emit = 1'b1;
								emit_report = 1'b1;
								emit_kind = dert_pkg::KIND_REPORT;
							end else if (expired) begin
								drop_cur = 1'b1;
							end
						end
						if (last_slot) state_d = dert_pkg::S_TAIL;
					end
					dert_pkg::OP_REMOVE: begin
						if (cur_valid && key_eq) begin
							drop_cur = 1'b1;
							emit = 1'b1;
							emit_last = 1'b1;
							emit_kind = dert_pkg::KIND_REMOVE;
							emit_status = cur_reported ? dert_pkg::ST_REPORTED
								: dert_pkg::ST_UNREPORTED;
							state_d = dert_pkg::S_IDLE;
						end else if (last_slot) begin
							state_d = dert_pkg::S_TAIL;
						end
					end
					default: state_d = dert_pkg::S_IDLE;
				endcase
			end
			dert_pkg::S_TAIL: begin
				emit = 1'b1;
				emit_last = 1'b1;
				state_d = dert_pkg::S_IDLE;
				case (op_q)
					dert_pkg::OP_ADD: begin
						emit_kind = dert_pkg::KIND_ACK;
						emit_status = hit_q ? dert_pkg::ST_REFRESHED
							: (free_q ? dert_pkg::ST_NEW : dert_pkg::ST_FULL);
					end
					dert_pkg::OP_TICK: emit_kind = dert_pkg::KIND_TICK_DONE;
					default: begin
						emit_kind = dert_pkg::KIND_REMOVE;
						emit_status = dert_pkg::ST_ABSENT;
					end
				endcase
			end
			default: state_d = dert_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dert_pkg::S_IDLE;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			strobe_q <= 1'b0;
			wait_delay_q <= dert_pkg::WAIT_DELAY_RST;
			retain_time_q <= dert_pkg::RETAIN_TIME_RST;
			for (int i = 0; i < N; i++) slot_valid_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= emit;
			if (accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end
			if (state_q == dert_pkg::S_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (op_q == dert_pkg::OP_ADD) begin
					if (cur_valid && !hit_q && full_eq) hit_q <= 1'b1;
					if (!cur_valid && !free_q) free_q <= 1'b1;
				end
			end
			if (drop_cur) slot_valid_q[idx_q] <= 1'b0;
			if (state_q == dert_pkg::S_TAIL && op_q == dert_pkg::OP_ADD && !hit_q && free_q)
				slot_valid_q[free_idx_q] <= 1'b1;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == dert_pkg::REG_WAIT_DELAY) wait_delay_q <= cfg_data[15:0];
				else if (cfg_index == dert_pkg::REG_RETAIN_TIME) retain_time_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			ev_q <= event_number;
			sn_q <= serial_number;
			key_paths_q <= {link_flag, near_path, far_cluster, far_path};
			now_q <= now_seconds;
		end
		if (state_q == dert_pkg::S_SCAN && op_q == dert_pkg::OP_ADD) begin
			if (cur_valid && !hit_q && full_eq) hit_idx_q <= idx_q;
			if (!cur_valid && !free_q) free_idx_q <= idx_q;
		end
		if (emit_report) slot_reported_q[idx_q] <= 1'b1;
		if (state_q == dert_pkg::S_TAIL && op_q == dert_pkg::OP_ADD && (hit_q || free_q)) begin
			slot_deadline_q[add_idx] <= {1'b0, now_q} + {17'd0, wait_delay_q};
			slot_reported_q[add_idx] <= 1'b0;
			if (!hit_q) begin
				slot_event_q[add_idx] <= ev_q;
				slot_serial_q[add_idx] <= sn_q;
				slot_paths_q[add_idx] <= key_paths_q;
			end
		end
		if (emit) begin
			kind_q <= emit_kind;
			status_q <= emit_status;
			last_q <= emit_last;
			out_event_q <= emit_report ? slot_event_q[idx_q] : 32'd0;
			out_serial_q <= emit_report ? slot_serial_q[idx_q] : 32'd0;
			out_paths_q <= emit_report ? slot_paths_q[idx_q] : 32'd0;
		end
	end

	assign strobe = strobe_q;
	assign kind = kind_q;
	assign status = status_q;
	assign out_event = out_event_q;
	assign out_serial = out_serial_q;
	assign out_far_path = out_paths_q[7:0];
	assign out_far_cluster = out_paths_q[15:8];
	assign out_near_path = out_paths_q[23:16];
	assign out_link_flag = out_paths_q[31:24];
	assign last = last_q;

endmodule
